@@ rtl/core/alse_pkg.sv @@
// ----------------------------------------------------------------------------
// alse_pkg
// Shared types and constants for the list search and edit engine: command
// and status codes, cell control word, result layout and controller states.
// ----------------------------------------------------------------------------
package alse_pkg;

  // fixed field widths
  localparam int DataW    = 32;
  localparam int CmdW     = 3;
  localparam int PosW     = 6;
  localparam int StatusW  = 2;
  localparam int TotalW   = 7;
  localparam int Capacity = 64;

  // packed beat widths
  localparam int InBits   = CmdW + PosW + DataW;
  localparam int OutBits  = StatusW + PosW + DataW + DataW + TotalW;
  localparam int InBytesW  = ((InBits + 7) / 8) * 8;
  localparam int OutBytesW = ((OutBits + 7) / 8) * 8;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_FIND   = 3'd0,
    CMD_MODIFY = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_ZERO   = 3'd4
  } cmd_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FINISH
  } state_e;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_FIND,
    CELL_PICK,
    CELL_WRITE,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [DataW-1:0]       value;
  } cell_ctrl_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [TotalW-1:0]      entry_total;
    logic [DataW-1:0]       new_value;
    logic [DataW-1:0]       old_value;
    logic [PosW-1:0]        found_position;
    status_e                status;
  } result_t;

endpackage

@@ rtl/core/alse_cell.sv @@
// ----------------------------------------------------------------------------
// alse_cell
// One list entry: holds its value, takes its right neighbor's value on a
// shift, and flags a hit for the priority tree on a find or a pick.
// ----------------------------------------------------------------------------
module alse_cell #(
  parameter int Index = 0,
  parameter int AW    = 6,
  parameter int CntW  = 7
) (
  input  logic                        clk_i,
  input  alse_pkg::cell_ctrl_t        ctrl_i,
  input  logic [AW-1:0]               sel_idx_i,
  input  logic [CntW-1:0]             count_i,
  input  logic [alse_pkg::DataW-1:0]  next_data_i,
  output logic [alse_pkg::DataW-1:0]  data_o,
  output logic                        hit_o
);

  logic [alse_pkg::DataW-1:0] data_q, data_d;
  logic                       hit_q, hit_d;
  logic                       live, selected, above;

  assign live     = count_i > CntW'(Index);
  assign selected = sel_idx_i == AW'(Index);
  assign above    = AW'(Index) >= sel_idx_i;

  // entry update and hit flag
  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    unique case (ctrl_i.op)
      alse_pkg::CELL_FIND:  hit_d = live && (data_q == ctrl_i.value);
      alse_pkg::CELL_PICK:  hit_d = selected;
      alse_pkg::CELL_WRITE: if (selected) data_d = ctrl_i.value;
      alse_pkg::CELL_SHIFT: if (above) data_d = next_data_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

@@ rtl/core/alse_prio_tree.sv @@
// ----------------------------------------------------------------------------
// alse_prio_tree
// Registered binary tree that picks the lowest flagged cell and returns its
// index and value; each tree level is registered, left child wins.
// ----------------------------------------------------------------------------
module alse_prio_tree #(
  parameter int Capacity = alse_pkg::Capacity,
  parameter int AW       = $clog2(Capacity)
) (
  input  logic                        clk_i,
  input  logic [Capacity-1:0]         hit_i,
  input  logic [alse_pkg::DataW-1:0]  data_i [Capacity],
  output logic                        found_o,
  output logic [AW-1:0]               idx_o,
  output logic [alse_pkg::DataW-1:0]  data_o
);

  localparam int NP = 1 << AW;

  typedef struct packed {
    logic                       v;
    logic [AW-1:0]              idx;
    logic [alse_pkg::DataW-1:0] data;
  } node_t;

  node_t leaf_w [NP];
  node_t node_q [NP-1];

  // leaves straight from the cells, padding leaves never hit
  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < Capacity) begin : g_real
      assign leaf_w[i] = '{v: hit_i[i], idx: AW'(i), data: data_i[i]};
    end else begin : g_pad
      assign leaf_w[i] = '0;
    end
  end

  // internal nodes in heap order, children of n at 2n+1 and 2n+2
  for (genvar n = 0; n < NP - 1; n++) begin : g_node
    node_t left_w, right_w;
    if (2 * n + 1 >= NP - 1) begin : g_leaf_kids
      assign left_w  = leaf_w[2 * n + 1 - (NP - 1)];
      assign right_w = leaf_w[2 * n + 2 - (NP - 1)];
    end else begin : g_node_kids
      assign left_w  = node_q[2 * n + 1];
      assign right_w = node_q[2 * n + 2];
    end
    always_ff @(posedge clk_i) begin
      node_q[n] <= left_w.v ? left_w : right_w;
    end
  end

  assign found_o = node_q[0].v;
  assign idx_o   = node_q[0].idx;
  assign data_o  = node_q[0].data;

endmodule

@@ rtl/core/array_list_search_edit_engine_unit.sv @@
// ----------------------------------------------------------------------------
// array_list_search_edit_engine_unit
// Packed list of signed 32-bit entries held in a row of cells, with find,
// modify, append, remove-with-shift and zero commands, one result per command.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata fields (lsb first)                       | beat
//  s_axis    | in  | cmd[3] position[6] operand_value[32], pad to 48 | one command
//  m_axis    | out | status[2] found_position[6] old_value[32]       | one result
//            |     | new_value[32] entry_total[7], pad to 80         |
//
//  append, remove, zero, range errors and unknown codes return their result from
//  S_EXEC; find and modify pass through S_SEARCH while the registered priority
//  tree settles, then return from S_FINISH. One command is in flight at a time; the
//  next is taken the cycle after its result is loaded into the output register.
//  rst_ni clears the live count and control only; entries stay undefined.
//  A stalled output holds its result and parks the controller before any
//  entry is changed.
// ----------------------------------------------------------------------------
module array_list_search_edit_engine_unit #(
  parameter int Capacity = alse_pkg::Capacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // cmd[2:0], position[8:3], operand_value[40:9], zero pad
  input  logic [alse_pkg::InBytesW-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status[1:0], found_position[7:2], old_value[39:8], new_value[71:40],
  // entry_total[78:72], zero pad
  output logic [alse_pkg::OutBytesW-1:0]  m_axis_tdata_o
);

  localparam int AW   = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int SW   = $clog2(AW + 1);

  // command registers
  logic [alse_pkg::CmdW-1:0]  cmd_q;
  logic [alse_pkg::PosW-1:0]  pos_q;
  logic [alse_pkg::DataW-1:0] val_q;

  alse_pkg::state_e   state_q, state_d;
  logic [SW-1:0]      wait_q, wait_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q, out_valid_d;
  alse_pkg::result_t  res_q, res_d;
  logic               res_load;

  logic               in_fire, out_free, pos_ok, full;
  alse_pkg::cell_ctrl_t ctrl;
  logic [AW-1:0]      sel_idx;

  logic [alse_pkg::DataW-1:0] cell_data [Capacity];
  logic [Capacity-1:0]        cell_hit;
  logic                       tree_found;
  logic [AW-1:0]              tree_idx;
  logic [alse_pkg::DataW-1:0] tree_data;

  assign s_axis_tready_o = state_q == alse_pkg::S_IDLE;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign pos_ok          = 32'(pos_q) < 32'(count_q);
  assign full            = count_q == CntW'(Capacity);

  // command capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tdata_i[alse_pkg::CmdW-1:0];
      pos_q <= s_axis_tdata_i[alse_pkg::CmdW +: alse_pkg::PosW];
      val_q <= s_axis_tdata_i[alse_pkg::CmdW + alse_pkg::PosW +: alse_pkg::DataW];
    end
  end

  // controller: next state, cell control and result
  always_comb begin
    logic done;
    done        = 1'b0;
    state_d     = state_q;
    wait_d      = wait_q;
    count_d     = count_q;
    ctrl.op     = alse_pkg::CELL_NONE;
    ctrl.value  = val_q;
    sel_idx     = AW'(pos_q);
    res_d       = '0;
    res_d.status = alse_pkg::ST_OK;
    res_load    = 1'b0;
    unique case (state_q)
      alse_pkg::S_IDLE: begin
        if (in_fire) state_d = alse_pkg::S_EXEC;
      end
      alse_pkg::S_EXEC: begin
        unique case (alse_pkg::cmd_e'(cmd_q))
          alse_pkg::CMD_FIND: begin
            ctrl.op = alse_pkg::CELL_FIND;
            wait_d  = SW'(AW - 1);
            state_d = alse_pkg::S_SEARCH;
          end
          alse_pkg::CMD_MODIFY: begin
            if (pos_ok) begin
              ctrl.op = alse_pkg::CELL_PICK;
              wait_d  = SW'(AW - 1);
              state_d = alse_pkg::S_SEARCH;
            end else begin
              done         = 1'b1;
              res_d.status = alse_pkg::ST_RANGE;
            end
          end
          alse_pkg::CMD_APPEND: begin
            done = 1'b1;
            if (full) begin
              res_d.status = alse_pkg::ST_FULL;
            end else begin
              ctrl.op = alse_pkg::CELL_WRITE;
              sel_idx = AW'(count_q);
              count_d = count_q + CntW'(1);
            end
          end
          alse_pkg::CMD_REMOVE: begin
            done = 1'b1;
            if (!pos_ok) begin
              res_d.status = alse_pkg::ST_RANGE;
            end else begin
              ctrl.op = alse_pkg::CELL_SHIFT;
              count_d = count_q - CntW'(1);
            end
          end
          alse_pkg::CMD_ZERO: begin
            done = 1'b1;
            if (!pos_ok) begin
              res_d.status = alse_pkg::ST_RANGE;
            end else begin
              ctrl.op    = alse_pkg::CELL_WRITE;
              ctrl.value = '0;
            end
          end
          default: done = 1'b1;
        endcase
      end
      alse_pkg::S_SEARCH: begin
        if (wait_q == '0) state_d = alse_pkg::S_FINISH;
        else wait_d = wait_q - SW'(1);
      end
      alse_pkg::S_FINISH: begin
        done = 1'b1;
        if (alse_pkg::cmd_e'(cmd_q) == alse_pkg::CMD_FIND) begin
          if (tree_found) res_d.found_position = alse_pkg::PosW'(tree_idx);
          else res_d.status = alse_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.op         = alse_pkg::CELL_WRITE;
          res_d.old_value = tree_data;
          res_d.new_value = val_q;
        end
      end
      default: state_d = alse_pkg::S_IDLE;
    endcase
    // park on a full output register before touching any entry
    if (done) begin
      if (out_free) begin
        res_load = 1'b1;
        state_d  = alse_pkg::S_IDLE;
      end else begin
        ctrl.op  = alse_pkg::CELL_NONE;
        count_d  = count_q;
      end
    end
    res_d.entry_total = alse_pkg::TotalW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alse_pkg::S_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = alse_pkg::OutBytesW'(res_q);

  // row of entry cells, each but the last shifting from its right neighbor
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [alse_pkg::DataW-1:0] next_w;
    if (i == Capacity - 1) begin : g_end
      assign next_w = cell_data[i];
    end else begin : g_mid
      assign next_w = cell_data[i + 1];
    end
    alse_cell #(
      .Index (i),
      .AW    (AW),
      .CntW  (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sel_idx_i   (sel_idx),
      .count_i     (count_q),
      .next_data_i (next_w),
      .data_o      (cell_data[i]),
      .hit_o       (cell_hit[i])
    );
  end

  // lowest-hit search over the row
  alse_prio_tree #(
    .Capacity (Capacity),
    .AW       (AW)
  ) u_tree (
    .clk_i   (clk_i),
    .hit_i   (cell_hit),
    .data_i  (cell_data),
    .found_o (tree_found),
    .idx_o   (tree_idx),
    .data_o  (tree_data)
  );

  // live count stays within the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Capacity)
    else $error("live count beyond capacity");

  // one command in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("second command taken while busy");

  // live count moves by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CntW'(1) ||
         count_q == $past(count_q) - CntW'(1)))
    else $error("live count jumped");

  // a full-list report carries a full count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == alse_pkg::ST_FULL) |->
      res_q.entry_total == alse_pkg::TotalW'(Capacity))
    else $error("full status with room left");

endmodule
